// ===== design/wpr_pkg.sv =====
// Types and constants shared by the working-set clock page replacement block.
`default_nettype none

package wpr_pkg;

    localparam int FRAMES  = 8;
    localparam int PAGES   = 16;
    localparam int FRAME_W = 3;
    localparam int PAGE_W  = 4;
    localparam int TIME_W  = 32;
    localparam int AGE_W   = 16;
    localparam int COUNT_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [AGE_W-1:0]   MAX_AGE_RESET = 16'd50;
    localparam logic [PADDR_W-1:0] ADDR_MAX_AGE  = 3'd0;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic              command;
        logic [PAGE_W-1:0] page;
        logic [TIME_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic               fault;
        logic [PAGE_W-1:0]  victim_page;
        logic [FRAME_W-1:0] frame_used;
        logic [COUNT_W-1:0] fault_total;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/wsclock_page_replacement.sv =====
// Top level of the working-set clock page replacement block.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   i_in_item  (command, page, now)
//   out       output     o_out_valid / i_out_stall o_out_item (hit, fault, victim, frame, total)
//   config    input      psel/penable/pwrite/pready paddr, pwdata, prdata (max_age)
//
// A tick or a hit passes from the accepted beat through the LOOK state to the result register.
// A fault goes through LOOK, then SCAN: the walk moves one frame a cycle through the shared age
// subtractor and compare, then the EVICT state writes the victim frame.
// Reset is synchronous and active low; it restores the initial frame mapping at once.
// A result waits in the output register while stalled; the next beat is accepted
// meanwhile, and the sequencer holds its final step until the register is free.
`default_nettype none

module wsclock_page_replacement (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wpr_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output wpr_pkg::t_out_item   o_out_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [wpr_pkg::PADDR_W-1:0] paddr,
    input  wire [wpr_pkg::PDATA_W-1:0] pwdata,
    output logic [wpr_pkg::PDATA_W-1:0] prdata,
    output logic                 pready
);
    import wpr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EVICT = 2'd3;

    logic [1:0]         r_state, n_state;
    logic               r_cmd;
    logic [PAGE_W-1:0]  r_page;
    logic [TIME_W-1:0]  r_now;
    logic [FRAME_W-1:0] r_hand, n_hand;
    logic [FRAME_W-1:0] r_walk, n_walk;
    logic [COUNT_W-1:0] r_fault_count, n_fault_count;
    logic [AGE_W-1:0]   r_max_age;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic [PAGE_W-1:0]  r_frame_page [FRAMES];
    logic [TIME_W-1:0]  r_frame_time [FRAMES];
    logic [FRAMES-1:0]  r_frame_ref;
    logic [PAGES-1:0]   r_page_resident;
    logic [FRAME_W-1:0] r_page_frame [PAGES];

    logic               out_free;
    logic [PAGE_W-1:0]  victim_page;
    logic [PAGE_W-1:0]  pf_addr;
    logic [FRAME_W-1:0] pf_frame;
    logic [FRAME_W-1:0] walk_next;
    logic [TIME_W-1:0]  age;
    logic               too_old;
    logic               cfg_write;

    logic               tick_clear;
    logic               hit_touch;
    logic               scan_touch;
    logic               evict_write;
    logic               victim_unmap;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign victim_page = r_frame_page[r_walk];
    // One read port into the page map: the victim's page during eviction, else the access.
    assign pf_addr     = (r_state == ST_EVICT) ? victim_page : r_page;
    assign pf_frame    = r_page_frame[pf_addr];
    assign walk_next   = (r_walk == FRAME_W'(FRAMES - 1)) ? '0 : r_walk + 1'b1;
    assign age         = r_now - r_frame_time[r_walk];
    assign too_old     = age > {{(TIME_W-AGE_W){1'b0}}, r_max_age};

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;
    assign prdata      = (paddr == ADDR_MAX_AGE) ?
                         {{(PDATA_W-AGE_W){1'b0}}, r_max_age} : '0;

    always_comb begin
        n_state       = r_state;
        n_hand        = r_hand;
        n_walk        = r_walk;
        n_fault_count = r_fault_count;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_item    = r_out_item;
        tick_clear    = 1'b0;
        hit_touch     = 1'b0;
        scan_touch    = 1'b0;
        evict_write   = 1'b0;
        victim_unmap  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (r_cmd == CMD_TICK) begin
                    if (out_free) begin
                        tick_clear  = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_item  = '{hit: 1'b0, fault: 1'b0, victim_page: '0,
                                        frame_used: '0, fault_total: r_fault_count};
                        n_state     = ST_IDLE;
                    end
                end else if (r_page_resident[r_page]) begin
                    if (out_free) begin
                        hit_touch   = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_item  = '{hit: 1'b1, fault: 1'b0, victim_page: '0,
                                        frame_used: pf_frame, fault_total: r_fault_count};
                        n_state     = ST_IDLE;
                    end
                end else begin
                    if (r_fault_count != '1) begin
                        n_fault_count = r_fault_count + 1'b1;
                    end
                    n_walk  = r_hand;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // At the latest, the walk ends on the frame just before the one it started from.
                if (walk_next == r_hand) begin
                    n_state = ST_EVICT;
                end else if (r_frame_ref[r_walk]) begin
                    scan_touch = 1'b1;
                    n_walk     = walk_next;
                end else if (too_old) begin
                    n_state = ST_EVICT;
                end else begin
                    n_walk = walk_next;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    evict_write  = 1'b1;
                    victim_unmap = r_page_resident[victim_page] && (pf_frame == r_walk);
                    n_hand       = r_walk;
                    n_out_valid  = 1'b1;
                    n_out_item   = '{hit: 1'b0, fault: 1'b1, victim_page: victim_page,
                                     frame_used: r_walk, fault_total: r_fault_count};
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_hand        <= '0;
            r_walk        <= '0;
            r_fault_count <= '0;
            r_max_age     <= MAX_AGE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_hand        <= n_hand;
            r_walk        <= n_walk;
            r_fault_count <= n_fault_count;
            r_out_valid   <= n_out_valid;
            if (cfg_write && (paddr == ADDR_MAX_AGE)) begin
                r_max_age <= pwdata[AGE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_cmd  <= i_in_item.command;
            r_page <= i_in_item.page;
            r_now  <= i_in_item.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FRAMES; f++) begin
                r_frame_page[f] <= PAGE_W'(f % PAGES);
                r_frame_time[f] <= '0;
            end
            r_frame_ref <= '0;
            for (int p = 0; p < PAGES; p++) begin
                r_page_resident[p] <= (p < FRAMES);
                r_page_frame[p]    <= (p < FRAMES) ? FRAME_W'(p) : '0;
            end
        end else begin
            if (tick_clear) begin
                r_frame_ref <= '0;
            end
            if (hit_touch) begin
                r_frame_time[pf_frame] <= r_now;
                r_frame_ref[pf_frame]  <= 1'b1;
            end
            if (scan_touch) begin
                r_frame_time[r_walk] <= r_now;
                r_frame_ref[r_walk]  <= 1'b0;
            end
            if (victim_unmap) begin
                r_page_resident[victim_page] <= 1'b0;
            end
            if (evict_write) begin
                r_frame_page[r_walk]    <= r_page;
                r_frame_time[r_walk]    <= r_now;
                r_frame_ref[r_walk]     <= 1'b1;
                r_page_resident[r_page] <= 1'b1;
                r_page_frame[r_page]    <= r_walk;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/wpr_checker.sv =====
// Port-level assertions for the page replacement block, bound to its top level.
`default_nettype none

module wpr_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_stall,
    input  wpr_pkg::t_in_item    i_in_item,
    input  wire                  o_out_valid,
    input  wire                  i_out_stall,
    input  wpr_pkg::t_out_item   o_out_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [wpr_pkg::PADDR_W-1:0] paddr,
    input  wire [wpr_pkg::PDATA_W-1:0] pwdata,
    input  wire [wpr_pkg::PDATA_W-1:0] prdata,
    input  wire                  pready
);
    import wpr_pkg::*;

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Accepting an item moves the block out of IDLE, which raises the input stall.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    a_hit_xor_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.hit && o_out_item.fault))
        else $error("result flags both hit and fault");

    // Without an eviction nothing names a victim, and a tick names no frame either.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.fault |->
            (o_out_item.victim_page == '0) &&
            (o_out_item.hit || (o_out_item.frame_used == '0)))
        else $error("victim or frame reported without cause");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.fault |-> (o_out_item.fault_total != '0))
        else $error("fault reported with a zero fault total");

endmodule

bind wsclock_page_replacement wpr_checker u_wpr_checker (.*);

`default_nettype wire
